### src/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

  localparam int PosW      = 24;
  localparam int HdW       = 16;
  localparam int SpdW      = 12;
  localparam int RateW     = 20;
  localparam int TgtW      = 10;
  localparam int CfgW      = 23;
  localparam int CfgIdxW   = 3;
  localparam int LookW     = 8;
  localparam int GainW     = 12;
  localparam int CordSteps = 15;
  localparam int CordW     = 48;
  localparam int CordShift = 20;
  localparam int CntW      = 4;

  typedef enum logic [1:0] {
    FUNC_NEW    = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEAVE_RADIUS = 3'd0,
    CFG_GOAL_RADIUS  = 3'd1,
    CFG_LOOKAHEAD    = 3'd2,
    CFG_TURN_THRESH  = 3'd3,
    CFG_SLOW_SPEED   = 3'd4,
    CFG_FAST_SPEED   = 3'd5,
    CFG_STEER_GAIN   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    K_LEAVE = 2'd0,
    K_GOAL  = 2'd1,
    K_SCAN  = 2'd2,
    K_TGT   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_LEAVE, S_GOAL, S_GOALW, S_SCAN, S_DRAIN,
    S_TGT, S_TGTW, S_CORD, S_ERR, S_MUL, S_OUT, S_DONE
  } state_e;

  typedef struct packed {
    logic  latch;
    logic  wr_path;
    logic  iss;
    kind_e iss_kind;
    logic  cord_load;
    logic  cord_step;
    logic  calc_err;
    logic  calc_mul;
    logic  out_res;
    logic  out_done;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic empty;
    logic goal_vld;
    logic goal_hit;
    logic scan_last;
    logic scan_done;
    logic tgt_rdy;
    logic cord_last;
  } sts_t;

  function automatic logic [HdW-1:0] atan_bau(input logic [CntW-1:0] i);
    logic [HdW-1:0] r;
    unique case (i)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      4'd13:   r = 16'd1;
      4'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

### src/pts_ctl.sv
`timescale 1ns / 1ps
module pts_ctl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    func_i,
  input  pts_pkg::sts_t sts_i,
  output pts_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import pts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (func_i)
            FUNC_NEW, FUNC_APPEND: state_d = S_WR;
            FUNC_TICK: begin
              if (sts_i.finished) begin
                state_d = S_DONE;
              end else if (!sts_i.empty) begin
                state_d = S_LEAVE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        cmd_o.wr_path = 1'b1;
        state_d       = S_IDLE;
      end
      S_LEAVE: begin
        cmd_o.iss      = 1'b1;
        cmd_o.iss_kind = K_LEAVE;
        state_d        = S_GOAL;
      end
      S_GOAL: begin
        cmd_o.iss      = 1'b1;
        cmd_o.iss_kind = K_GOAL;
        state_d        = S_GOALW;
      end
      S_GOALW: begin
        if (sts_i.goal_vld) begin
          state_d = sts_i.goal_hit ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.iss      = 1'b1;
        cmd_o.iss_kind = K_SCAN;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.scan_done) begin
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        cmd_o.iss      = 1'b1;
        cmd_o.iss_kind = K_TGT;
        state_d        = S_TGTW;
      end
      S_TGTW: begin
        if (sts_i.tgt_rdy) begin
          cmd_o.cord_load = 1'b1;
          state_d         = S_CORD;
        end
      end
      S_CORD: begin
        cmd_o.cord_step = 1'b1;
        if (sts_i.cord_last) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_res = 1'b1;
        state_d       = S_IDLE;
      end
      S_DONE: begin
        cmd_o.out_done = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### src/pts_dp.sv
`timescale 1ns / 1ps
module pts_dp #(
  parameter int PATH_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pts_pkg::cmd_t                      cmd_i,
  output pts_pkg::sts_t                      sts_o,
  input  logic [1:0]                         func_i,
  input  logic signed [pts_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [pts_pkg::PosW-1:0]    pos_y_i,
  input  logic signed [pts_pkg::HdW-1:0]     heading_i,
  input  logic                               cfg_we_i,
  input  logic [pts_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pts_pkg::CfgW-1:0]           cfg_data_i,
  output logic                               result_valid_o,
  output logic [pts_pkg::SpdW-1:0]           linear_speed_o,
  output logic signed [pts_pkg::RateW-1:0]   angular_rate_o,
  output logic                               goal_done_o,
  output logic [pts_pkg::TgtW-1:0]           target_index_o
);
  import pts_pkg::*;

  localparam int AW     = $clog2(PATH_DEPTH);
  localparam int CW     = $clog2(PATH_DEPTH + 1);
  localparam int SW     = ((AW > LookW) ? AW : LookW) + 1;
  localparam int DW     = PosW + 1;
  localparam int SqW    = 2 * DW;
  localparam int DistW  = SqW + 1;
  localparam int RadSqW = 2 * CfgW;
  localparam int MagW   = HdW + 1;
  localparam int ProdW  = MagW + GainW;
  localparam logic [CW-1:0] DepthC = CW'(PATH_DEPTH);

  // configuration
  logic [CfgW-1:0]  lr_q, gr_q;
  logic [LookW-1:0] look_q;
  logic [HdW-1:0]   thr_q;
  logic [SpdW-1:0]  slow_q, fast_q;
  logic [GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= 23'd4096;
      gr_q   <= 23'd1638;
      look_q <= 8'd10;
      thr_q  <= 16'd4172;
      slow_q <= 12'd50;
      fast_q <= 12'd150;
      gain_q <= 12'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEAVE_RADIUS: lr_q   <= cfg_data_i;
        CFG_GOAL_RADIUS:  gr_q   <= cfg_data_i;
        CFG_LOOKAHEAD:    look_q <= cfg_data_i[LookW-1:0];
        CFG_TURN_THRESH:  thr_q  <= cfg_data_i[HdW-1:0];
        CFG_SLOW_SPEED:   slow_q <= cfg_data_i[SpdW-1:0];
        CFG_FAST_SPEED:   fast_q <= cfg_data_i[SpdW-1:0];
        CFG_STEER_GAIN:   gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  logic [RadSqW-1:0] lr_sq_q, gr_sq_q;
  always_ff @(posedge clk_i) begin
    lr_sq_q <= lr_q * lr_q;
    gr_sq_q <= gr_q * gr_q;
  end

  // latched transaction
  logic [1:0]              func_q;
  logic signed [PosW-1:0]  px_q, py_q;
  logic [HdW-1:0]          hd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      hd_q   <= heading_i;
    end
  end

  // path store
  logic signed [PosW-1:0] mem_x [PATH_DEPTH];
  logic signed [PosW-1:0] mem_y [PATH_DEPTH];
  logic [CW-1:0] count_q;
  logic [AW-1:0] wr_addr, rd_addr, last, tgt, scan_idx_q;
  logic          wr_en;
  logic [SW-1:0] tgt_sum;
  logic [AW-1:0] best_q;

  assign wr_en   = cmd_i.wr_path && ((func_q == FUNC_NEW) || (count_q < DepthC));
  assign wr_addr = (func_q == FUNC_NEW) ? '0 : count_q[AW-1:0];
  assign last    = AW'(count_q - CW'(1));
  assign tgt_sum = SW'(best_q) + SW'(look_q);
  assign tgt     = (tgt_sum > SW'(last)) ? last : tgt_sum[AW-1:0];

  always_comb begin
    unique case (cmd_i.iss_kind)
      K_LEAVE: rd_addr = '0;
      K_GOAL:  rd_addr = last;
      K_SCAN:  rd_addr = scan_idx_q;
      K_TGT:   rd_addr = tgt;
    endcase
  end

  logic signed [PosW-1:0] rd_x_q, rd_y_q;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= px_q;
      mem_y[wr_addr] <= py_q;
    end
    if (cmd_i.iss) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.wr_path) begin
      if (func_q == FUNC_NEW) begin
        count_q <= CW'(1);
      end else if (count_q < DepthC) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      scan_idx_q <= '0;
    end else if (cmd_i.iss && cmd_i.iss_kind == K_SCAN) begin
      scan_idx_q <= scan_idx_q + AW'(1);
    end
  end

  // distance pipeline: read, difference, squares, compare
  logic          a_vld_q, b_vld_q, c_vld_q;
  kind_e         a_kind_q, b_kind_q, c_kind_q;
  logic [AW-1:0] a_idx_q, b_idx_q, c_idx_q;
  logic          a_last_q, b_last_q, c_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= cmd_i.iss;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  logic signed [DW-1:0] pxe, pye, rxe, rye, dx_d, dy_d, dx_q, dy_q;
  logic signed [SqW-1:0] sqx_d, sqy_d;
  logic [SqW-1:0]       sqx_q, sqy_q;

  assign pxe  = {px_q[PosW-1], px_q};
  assign pye  = {py_q[PosW-1], py_q};
  assign rxe  = {rd_x_q[PosW-1], rd_x_q};
  assign rye  = {rd_y_q[PosW-1], rd_y_q};
  assign dx_d = (a_kind_q == K_LEAVE) ? pxe : rxe - pxe;
  assign dy_d = (a_kind_q == K_LEAVE) ? pye : rye - pye;
  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    a_kind_q <= cmd_i.iss_kind;
    a_idx_q  <= rd_addr;
    a_last_q <= (rd_addr == last);
    b_kind_q <= a_kind_q;
    b_idx_q  <= a_idx_q;
    b_last_q <= a_last_q;
    c_kind_q <= b_kind_q;
    c_idx_q  <= b_idx_q;
    c_last_q <= b_last_q;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sqx_q    <= sqx_d;
    sqy_q    <= sqy_d;
  end

  logic             left_q, fin_q, goal_vld_q, goal_hit_q, scan_done_q;
  logic [DistW-1:0] sq_sum, best_d_q;
  logic             goal_hit;
  assign sq_sum   = DistW'(sqx_q) + DistW'(sqy_q);
  assign goal_hit = left_q && (sq_sum < DistW'(gr_sq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= 1'b0;
      fin_q       <= 1'b0;
      goal_vld_q  <= 1'b0;
      goal_hit_q  <= 1'b0;
      scan_done_q <= 1'b0;
    end else begin
      goal_vld_q  <= 1'b0;
      scan_done_q <= 1'b0;
      if (c_vld_q) begin
        unique case (c_kind_q)
          K_LEAVE: begin
            if (sq_sum > DistW'(lr_sq_q)) begin
              left_q <= 1'b1;
            end
          end
          K_GOAL: begin
            goal_vld_q <= 1'b1;
            goal_hit_q <= goal_hit;
            if (goal_hit) begin
              fin_q <= 1'b1;
            end
          end
          K_SCAN: scan_done_q <= c_last_q;
          K_TGT: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_vld_q && c_kind_q == K_SCAN && ((c_idx_q == '0) || (sq_sum < best_d_q))) begin
      best_q   <= c_idx_q;
      best_d_q <= sq_sum;
    end
  end

  // vectoring cordic, one step per cycle
  logic signed [CordW-1:0] cx_q, cy_q, xs, ys;
  logic [HdW-1:0]          ang_q, atan_i;
  logic [CntW-1:0]         cnt_q;
  logic                    zero_q;
  logic signed [DW-1:0]    dxn, dyn;
  logic                    dneg;

  function automatic logic signed [CordW-1:0] shr_trunc(input logic signed [CordW-1:0] v,
                                                        input logic [CntW-1:0] s);
    logic signed [CordW-1:0] r;
    if (v[CordW-1]) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

  assign dneg   = dx_q[DW-1];
  assign dxn    = dneg ? -dx_q : dx_q;
  assign dyn    = dneg ? -dy_q : dy_q;
  assign xs     = shr_trunc(cx_q, cnt_q);
  assign ys     = shr_trunc(cy_q, cnt_q);
  assign atan_i = atan_bau(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cord_load) begin
      cx_q   <= {{(CordW - DW - CordShift){dxn[DW-1]}}, dxn, {CordShift{1'b0}}};
      cy_q   <= {{(CordW - DW - CordShift){dyn[DW-1]}}, dyn, {CordShift{1'b0}}};
      ang_q  <= dneg ? 16'h8000 : 16'h0000;
      zero_q <= (dx_q == '0) && (dy_q == '0);
      cnt_q  <= '0;
    end else if (cmd_i.cord_step) begin
      if (cy_q > 0) begin
        cx_q  <= cx_q + ys;
        cy_q  <= cy_q - xs;
        ang_q <= ang_q + atan_i;
      end else begin
        cx_q  <= cx_q - ys;
        cy_q  <= cy_q + xs;
        ang_q <= ang_q - atan_i;
      end
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // heading error, gain and result
  logic [HdW-1:0]        bear, err;
  logic signed [MagW-1:0] errs;
  logic [MagW-1:0]       mag_q;
  logic                  neg_q;
  logic [ProdW-1:0]      prod_q;
  logic [RateW-1:0]      rate_mag, rate;

  assign bear     = zero_q ? '0 : ang_q;
  assign err      = bear - hd_q;
  assign errs     = {err[HdW-1], err};
  assign rate_mag = RateW'(prod_q >> 8);
  assign rate     = neg_q ? -rate_mag : rate_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_err) begin
      mag_q <= err[HdW-1] ? MagW'(-errs) : MagW'(errs);
      neg_q <= err[HdW-1];
    end
    if (cmd_i.calc_mul) begin
      prod_q <= mag_q * gain_q;
    end
  end

  logic valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_res || cmd_i.out_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_res) begin
      linear_speed_o <= (mag_q > MagW'(thr_q)) ? slow_q : fast_q;
      angular_rate_o <= rate;
      goal_done_o    <= 1'b0;
      target_index_o <= TgtW'(tgt);
    end else if (cmd_i.out_done) begin
      linear_speed_o <= '0;
      angular_rate_o <= '0;
      goal_done_o    <= 1'b1;
      target_index_o <= '0;
    end
  end

  assign result_valid_o = valid_q;

  assign sts_o.finished  = fin_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.goal_vld  = goal_vld_q;
  assign sts_o.goal_hit  = goal_hit_q;
  assign sts_o.scan_last = (scan_idx_q == last);
  assign sts_o.scan_done = scan_done_q;
  assign sts_o.tgt_rdy   = b_vld_q && (b_kind_q == K_TGT);
  assign sts_o.cord_last = (cnt_q == CntW'(CordSteps - 1));

endmodule

### src/path_tracking_steering.sv
`timescale 1ns / 1ps
// channel  | signals                                           | dir | handshake
// -------- | ------------------------------------------------- | --- | ------------------
// command  | func_i pos_x_i pos_y_i heading_i                  | in  | start and not busy
// result   | linear_speed_o angular_rate_o goal_done_o         | out | result_valid_o
//          | target_index_o                                    |     | one cycle strobe
// config   | cfg_we_i cfg_idx_i cfg_data_i                     | in  | cfg_we_i
//
// a path write latches the point at start and stores it in S_WR; a finished goal's tick goes via S_DONE
// the length of a full tick is set by the one-point-per-cycle nearest scan
// through the path memory read port plus 15 cordic steps
// reset is asynchronous active low; the path memory is not cleared
// the receiver cannot stall: a result shows for one cycle, while the next command may start
module path_tracking_steering #(
  parameter int PATH_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func_i,
  input  logic signed [pts_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [pts_pkg::PosW-1:0]    pos_y_i,
  input  logic signed [pts_pkg::HdW-1:0]     heading_i,
  input  logic                               cfg_we_i,
  input  logic [pts_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pts_pkg::CfgW-1:0]           cfg_data_i,
  output logic                               result_valid_o,
  output logic [pts_pkg::SpdW-1:0]           linear_speed_o,
  output logic signed [pts_pkg::RateW-1:0]   angular_rate_o,
  output logic                               goal_done_o,
  output logic [pts_pkg::TgtW-1:0]           target_index_o
);
  import pts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pts_ctl u_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  pts_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .heading_i      (heading_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .linear_speed_o (linear_speed_o),
    .angular_rate_o (angular_rate_o),
    .goal_done_o    (goal_done_o),
    .target_index_o (target_index_o)
  );

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && goal_done_o |-> linear_speed_o == '0 && angular_rate_o == '0)
    else $error("motors not locked on goal result");

  a_out_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.out_res && cmd.out_done))
    else $error("two result kinds in one cycle");
`endif

endmodule
